@@ rtl/pdk_pkg.sv @@
// ----------------------------------------------------------------------------
// pdk_pkg
// Shared widths, codes, word types and the CORDIC arctangent table for the
// pre-dock pose pipeline.
// ----------------------------------------------------------------------------
package pdk_pkg;

  localparam int COORD_BITS       = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int D_W              = 16;
  localparam int SC_W             = 30;             // scaled leg vector magnitude
  localparam int NORM_W           = SC_W + 1;       // floor sqrt of scaled length^2
  localparam int SQ_W             = 2 * NORM_W;
  localparam int NUM_W            = SC_W + D_W + 1;
  localparam int QUOT_W           = D_W + 1;
  localparam int OFF_W            = QUOT_W + 1;
  localparam int CORD_W           = 34;
  localparam int ANG_W            = 32;
  localparam int HEAD_W           = 16;
  localparam int ST_W             = 2;

  localparam logic [D_W-1:0]  STANDOFF_RESET = D_W'(614);

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_COINCIDE = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_D   = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left_leg_x;
    logic signed [COORD_BITS-1:0] left_leg_y;
    logic signed [COORD_BITS-1:0] right_leg_x;
    logic signed [COORD_BITS-1:0] right_leg_y;
    logic signed [COORD_BITS-1:0] robot_x;
    logic signed [COORD_BITS-1:0] robot_y;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]              status;
    logic signed [COORD_BITS-1:0] goal_x;
    logic signed [COORD_BITS-1:0] goal_y;
    logic signed [HEAD_W-1:0]     goal_heading;
  } out_word_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
    logic [ANG_W-1:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/predock_pose_from_leg_pair_top.sv @@
// ----------------------------------------------------------------------------
// predock_pose_from_leg_pair_top
// Pre-dock goal from two shelf legs and the robot position.
// Datapath: registered stages around the 31-stage square root, the 17-stage
//   divider and the CORDIC stages.
// Throughput: one word per cycle; the whole pipeline holds while the output
//   word waits.
// Reset: rst clears all valid bits; standoff_distance returns to 614.
// ----------------------------------------------------------------------------
module predock_pose_from_leg_pair_top #(
  parameter int CORDIC_STEPS = pdk_pkg::CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pdk_pkg::in_word_t        in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pdk_pkg::out_word_t       out_word,
  input  logic                     cfg_we,
  input  logic [pdk_pkg::D_W-1:0]  cfg_data
);
  import pdk_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int PW    = $clog2(CB + 1);
  localparam int EX_W  = CB + 2;
  localparam int PR_W  = OFF_W + EX_W;
  localparam int G_W   = ((CB > OFF_W) ? CB : OFF_W) + 3;
  localparam int P_W   = D_W + SC_W;
  localparam int SQ_SIDE_W  = 2 * P_W + 2 * SC_W + 2 + 2 * (CB + 1) + 2 * CB + ST_W;
  localparam int DV_SIDE_W  = 2 * SC_W + 2 + 2 * (CB + 1) + 2 * CB + ST_W;
  localparam int CR_SIDE_W  = 2 * CB + ST_W;
  localparam logic signed [G_W-1:0] C_MAX =
    $signed({{(G_W-CB+1){1'b0}}, {(CB-1){1'b1}}});
  localparam logic signed [G_W-1:0] C_MIN = -C_MAX - G_W'(1);

  logic en;
  logic [D_W-1:0] standoff;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      standoff <= STANDOFF_RESET;
    end else if (cfg_we) begin
      standoff <= cfg_data;
    end
  end

  // stage 1: differences, doubled midpoint, status
  logic                 v1;
  logic signed [CB:0]   vx1, vy1, cx1, cy1;
  logic signed [CB-1:0] px1, py1;
  logic [D_W-1:0]       d1;
  logic [ST_W-1:0]      st1;
  logic signed [CB:0]   vx_next, vy_next;
  logic [ST_W-1:0]      st_next;

  always_comb begin
    vx_next = (CB+1)'(in_word.right_leg_x) - (CB+1)'(in_word.left_leg_x);
    vy_next = (CB+1)'(in_word.right_leg_y) - (CB+1)'(in_word.left_leg_y);
    if (standoff == '0) begin
      st_next = ST_ZERO_D;
    end else if (vx_next == '0 && vy_next == '0) begin
      st_next = ST_COINCIDE;
    end else begin
      st_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      vx1 <= vx_next;
      vy1 <= vy_next;
      cx1 <= (CB+1)'(in_word.left_leg_x) + (CB+1)'(in_word.right_leg_x);
      cy1 <= (CB+1)'(in_word.left_leg_y) + (CB+1)'(in_word.right_leg_y);
      px1 <= in_word.robot_x;
      py1 <= in_word.robot_y;
      d1  <= standoff;
      st1 <= st_next;
    end
  end

  // stage 2: magnitudes scaled so the larger lies in [2^29, 2^30)
  logic                 v2;
  logic [SC_W-1:0]      ax2, ay2;
  logic                 negx2, negy2;
  logic signed [CB:0]   cx2, cy2;
  logic signed [CB-1:0] px2, py2;
  logic [D_W-1:0]       d2;
  logic [ST_W-1:0]      st2;
  logic [CB:0]          absx, absy;
  logic [CB-1:0]        mag;
  logic [PW-1:0]        msb;
  logic [63:0]          wx, wy;

  always_comb begin
    absx = vx1[CB] ? -vx1 : vx1;
    absy = vy1[CB] ? -vy1 : vy1;
    mag  = (absx > absy) ? absx[CB-1:0] : absy[CB-1:0];
    msb  = '0;
    for (int j = 0; j < CB; j++) begin
      if (mag[j]) begin
        msb = PW'(j);
      end
    end
    wx = (64'(absx[CB-1:0]) << (SC_W - 1)) >> msb;
    wy = (64'(absy[CB-1:0]) << (SC_W - 1)) >> msb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ax2   <= wx[SC_W-1:0];
      ay2   <= wy[SC_W-1:0];
      negx2 <= vx1[CB];
      negy2 <= vy1[CB];
      cx2   <= cx1;
      cy2   <= cy1;
      px2   <= px1;
      py2   <= py1;
      d2    <= d1;
      st2   <= st1;
    end
  end

  // stage 3: squared length and standoff products
  logic                   v3;
  logic [SQ_W-1:0]        n3;
  logic [P_W-1:0]         pa3, pb3;
  logic [DV_SIDE_W-1:0]   side3;
  logic [2*SC_W-1:0]      sqx, sqy;

  always_comb begin
    sqx = ax2 * ax2;
    sqy = ay2 * ay2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      n3    <= SQ_W'(sqx) + SQ_W'(sqy);
      pa3   <= d2 * ay2;
      pb3   <= d2 * ax2;
      side3 <= {ax2, ay2, negx2, negy2, cx2, cy2, px2, py2, st2};
    end
  end

  logic                 vs;
  logic [NORM_W-1:0]    norm;
  logic [SQ_SIDE_W-1:0] side_s;

  pdk_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .radicand (n3),
    .side_in  ({pa3, pb3, side3}),
    .out_valid(vs),
    .root     (norm),
    .side_out (side_s)
  );

  // stage 4: rounding bias
  logic                 v4;
  logic [NUM_W-1:0]     numa4, numb4;
  logic [NORM_W-1:0]    norm4;
  logic [DV_SIDE_W-1:0] side4;
  logic [P_W-1:0]       pas, pbs;

  assign pas = side_s[SQ_SIDE_W-1 -: P_W];
  assign pbs = side_s[SQ_SIDE_W-P_W-1 -: P_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vs;
    end
    if (en) begin
      numa4 <= NUM_W'(pas) + NUM_W'(norm >> 1);
      numb4 <= NUM_W'(pbs) + NUM_W'(norm >> 1);
      norm4 <= norm;
      side4 <= side_s[DV_SIDE_W-1:0];
    end
  end

  logic                 vd;
  logic [QUOT_W-1:0]    qa, qb;
  logic [DV_SIDE_W-1:0] side_d;

  pdk_div #(.SIDE_W(DV_SIDE_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .num_a    (numa4),
    .num_b    (numb4),
    .den      (norm4),
    .side_in  (side4),
    .out_valid(vd),
    .quot_a   (qa),
    .quot_b   (qb),
    .side_out (side_d)
  );

  logic [SC_W-1:0]      axd, ayd;
  logic                 negxd, negyd;
  logic signed [CB:0]   cxd, cyd;
  logic signed [CB-1:0] pxd, pyd;
  logic [ST_W-1:0]      std;

  assign {axd, ayd, negxd, negyd, cxd, cyd, pxd, pyd, std} = side_d;

  // stage 5: signed offsets, midpoint minus robot
  logic                    v5;
  logic signed [OFF_W-1:0] offx5, offy5;
  logic signed [EX_W-1:0]  ex5, ey5;
  logic [SC_W-1:0]         ax5, ay5;
  logic                    negx5, negy5;
  logic signed [CB:0]      cx5, cy5;
  logic [ST_W-1:0]         st5;
  logic signed [OFF_W-1:0] qas, qbs;

  assign qas = $signed({1'b0, qa});
  assign qbs = $signed({1'b0, qb});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vd;
    end
    if (en) begin
      offx5 <= negyd ? qas : -qas;
      offy5 <= negxd ? -qbs : qbs;
      ex5   <= EX_W'(cxd) - (EX_W'(pxd) <<< 1);
      ey5   <= EX_W'(cyd) - (EX_W'(pyd) <<< 1);
      ax5   <= axd;
      ay5   <= ayd;
      negx5 <= negxd;
      negy5 <= negyd;
      cx5   <= cxd;
      cy5   <= cyd;
      st5   <= std;
    end
  end

  // stage 6: dot product terms
  logic                    v6;
  logic signed [PR_W-1:0]  prx6, pry6;
  logic signed [OFF_W-1:0] offx6, offy6;
  logic [SC_W-1:0]         ax6, ay6;
  logic                    negx6, negy6;
  logic signed [CB:0]      cx6, cy6;
  logic [ST_W-1:0]         st6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      prx6  <= PR_W'(offx5) * PR_W'(ex5);
      pry6  <= PR_W'(offy5) * PR_W'(ey5);
      offx6 <= offx5;
      offy6 <= offy5;
      ax6   <= ax5;
      ay6   <= ay5;
      negx6 <= negx5;
      negy6 <= negy5;
      cx6   <= cx5;
      cy6   <= cy5;
      st6   <= st5;
    end
  end

  // stage 7: side choice, rounded and saturated goal, heading vector
  logic                     v7;
  logic signed [CB-1:0]     gx7, gy7;
  logic signed [CORD_W-1:0] hx7, hy7;
  logic [ST_W-1:0]          st7;
  logic signed [PR_W:0]     dot;
  logic                     plus;
  logic signed [G_W-1:0]    gxw, gyw, gxr, gyr, gxs, gys;
  logic signed [CORD_W-1:0] sx, sy;

  always_comb begin
    dot  = (PR_W+1)'(prx6) + (PR_W+1)'(pry6);
    plus = dot <= 0;
    if (plus) begin
      gxw = G_W'(cx6) + (G_W'(offx6) <<< 1);
      gyw = G_W'(cy6) + (G_W'(offy6) <<< 1);
    end else begin
      gxw = G_W'(cx6) - (G_W'(offx6) <<< 1);
      gyw = G_W'(cy6) - (G_W'(offy6) <<< 1);
    end
    gxr = (gxw + G_W'(1)) >>> 1;
    gyr = (gyw + G_W'(1)) >>> 1;
    gxs = (gxr > C_MAX) ? C_MAX : ((gxr < C_MIN) ? C_MIN : gxr);
    gys = (gyr > C_MAX) ? C_MAX : ((gyr < C_MIN) ? C_MIN : gyr);
    sx  = negx6 ? -$signed(CORD_W'(ax6)) : $signed(CORD_W'(ax6));
    sy  = negy6 ? -$signed(CORD_W'(ay6)) : $signed(CORD_W'(ay6));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      gx7 <= gxs[CB-1:0];
      gy7 <= gys[CB-1:0];
      hx7 <= plus ? sy : -sy;
      hy7 <= plus ? -sx : sx;
      st7 <= st6;
    end
  end

  logic                 vc;
  logic [ANG_W-1:0]     ang;
  logic [CR_SIDE_W-1:0] side_c;
  logic signed [CB-1:0] gxc, gyc;
  logic [ST_W-1:0]      stc;
  logic [ANG_W-1:0]     ang_r;

  pdk_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(CR_SIDE_W)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .x_in     (hx7),
    .y_in     (hy7),
    .side_in  ({gx7, gy7, st7}),
    .out_valid(vc),
    .angle    (ang),
    .side_out (side_c)
  );

  assign {gxc, gyc, stc} = side_c;
  assign ang_r = ang + ANG_W'(32'h8000);

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vc;
    end
    if (en) begin
      out_word.status <= stc;
      if (stc == ST_OK) begin
        out_word.goal_x       <= gxc;
        out_word.goal_y       <= gyc;
        out_word.goal_heading <= $signed(ang_r[ANG_W-1 -: HEAD_W]);
      end else begin
        out_word.goal_x       <= '0;
        out_word.goal_y       <= '0;
        out_word.goal_heading <= '0;
      end
    end
  end

  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_OK |->
      out_word.goal_x == '0 && out_word.goal_y == '0 && out_word.goal_heading == '0)
    else $error("failed word carries a nonzero goal");

  a_ok_legs : assert property (@(posedge clk) disable iff (rst)
    v1 && st1 == ST_OK |-> (vx1 != '0 || vy1 != '0) && d1 != '0)
    else $error("ok status with coincident legs or zero standoff");

  a_scaled : assert property (@(posedge clk) disable iff (rst)
    v2 && st2 == ST_OK |-> ax2[SC_W-1] || ay2[SC_W-1])
    else $error("leg vector not normalized");

  a_reset_idle : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid right after reset");

endmodule

@@ rtl/pdk_sqrt.sv @@
// ----------------------------------------------------------------------------
// pdk_sqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module pdk_sqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [pdk_pkg::SQ_W-1:0]  radicand,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      out_valid,
  output logic [pdk_pkg::NORM_W-1:0] root,
  output logic [SIDE_W-1:0]         side_out
);
  import pdk_pkg::*;

  localparam int REM_W = NORM_W + 2;
  localparam int CUR_W = NORM_W + 4;

  logic [REM_W-1:0]  rem_q  [NORM_W+1];
  logic [NORM_W-1:0] root_q [NORM_W+1];
  logic [SQ_W-1:0]   rad_q  [NORM_W+1];
  logic [SIDE_W-1:0] side_q [NORM_W+1];
  logic              vld    [NORM_W+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = radicand;
  assign side_q[0] = side_in;
  assign vld[0]    = in_valid;

  for (genvar i = 1; i <= NORM_W; i++) begin : g_stage
    logic [CUR_W-1:0]  cur;
    logic [CUR_W-1:0]  trial;
    logic [CUR_W-1:0]  diff;
    logic [REM_W-1:0]  rem_next;
    logic [NORM_W-1:0] root_next;

    always_comb begin
      cur   = {rem_q[i-1], rad_q[i-1][SQ_W-1 -: 2]};
      trial = CUR_W'({root_q[i-1], 2'b01});
      diff  = cur - trial;
      if (cur >= trial) begin
        rem_next  = diff[REM_W-1:0];
        root_next = {root_q[i-1][NORM_W-2:0], 1'b1};
      end else begin
        rem_next  = cur[REM_W-1:0];
        root_next = {root_q[i-1][NORM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
      if (en) begin
        rem_q[i]  <= rem_next;
        root_q[i] <= root_next;
        rad_q[i]  <= {rad_q[i-1][SQ_W-3:0], 2'b00};
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign out_valid = vld[NORM_W];
  assign root      = root_q[NORM_W];
  assign side_out  = side_q[NORM_W];

endmodule

@@ rtl/pdk_div.sv @@
// ----------------------------------------------------------------------------
// pdk_div
// Pipelined restoring divider, two numerators over one divisor, one
// quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module pdk_div #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [pdk_pkg::NUM_W-1:0]  num_a,
  input  logic [pdk_pkg::NUM_W-1:0]  num_b,
  input  logic [pdk_pkg::NORM_W-1:0] den,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic [pdk_pkg::QUOT_W-1:0] quot_a,
  output logic [pdk_pkg::QUOT_W-1:0] quot_b,
  output logic [SIDE_W-1:0]          side_out
);
  import pdk_pkg::*;

  logic [NORM_W-1:0] rem_q  [QUOT_W+1][2];
  logic [QUOT_W-1:0] lo_q   [QUOT_W+1][2];
  logic [QUOT_W-1:0] q_q    [QUOT_W+1][2];
  logic [NORM_W-1:0] den_q  [QUOT_W+1];
  logic [SIDE_W-1:0] side_q [QUOT_W+1];
  logic              vld    [QUOT_W+1];

  assign rem_q[0][0] = NORM_W'(num_a >> QUOT_W);
  assign rem_q[0][1] = NORM_W'(num_b >> QUOT_W);
  assign lo_q[0][0]  = num_a[QUOT_W-1:0];
  assign lo_q[0][1]  = num_b[QUOT_W-1:0];
  assign q_q[0][0]   = '0;
  assign q_q[0][1]   = '0;
  assign den_q[0]    = den;
  assign side_q[0]   = side_in;
  assign vld[0]      = in_valid;

  for (genvar i = 1; i <= QUOT_W; i++) begin : g_stage
    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [NORM_W:0] cur;
      logic [NORM_W:0] diff;
      logic            take;

      always_comb begin
        cur  = {rem_q[i-1][k], lo_q[i-1][k][QUOT_W-1]};
        diff = cur - {1'b0, den_q[i-1]};
        take = cur >= {1'b0, den_q[i-1]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i][k] <= take ? diff[NORM_W-1:0] : cur[NORM_W-1:0];
          lo_q[i][k]  <= {lo_q[i-1][k][QUOT_W-2:0], 1'b0};
          q_q[i][k]   <= {q_q[i-1][k][QUOT_W-2:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
      if (en) begin
        den_q[i]  <= den_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign out_valid = vld[QUOT_W];
  assign quot_a    = q_q[QUOT_W][0];
  assign quot_b    = q_q[QUOT_W][1];
  assign side_out  = side_q[QUOT_W];

endmodule

@@ rtl/pdk_cordic.sv @@
// ----------------------------------------------------------------------------
// pdk_cordic
// Pipelined CORDIC vectoring: angle of (x, y), 2^32 per turn, one
// micro-rotation per stage after a half-turn pre-rotation stage.
// ----------------------------------------------------------------------------
module pdk_cordic #(
  parameter int STEPS  = pdk_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [pdk_pkg::CORD_W-1:0] x_in,
  input  logic signed [pdk_pkg::CORD_W-1:0] y_in,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic [pdk_pkg::ANG_W-1:0]         angle,
  output logic [SIDE_W-1:0]                 side_out
);
  import pdk_pkg::*;

  logic signed [CORD_W-1:0] x_q    [STEPS+1];
  logic signed [CORD_W-1:0] y_q    [STEPS+1];
  logic [ANG_W-1:0]         ang_q  [STEPS+1];
  logic [SIDE_W-1:0]        side_q [STEPS+1];
  logic                     vld    [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      if (x_in < 0) begin
        x_q[0]   <= -x_in;
        y_q[0]   <= -y_in;
        ang_q[0] <= {1'b1, {(ANG_W-1){1'b0}}};
      end else begin
        x_q[0]   <= x_in;
        y_q[0]   <= y_in;
        ang_q[0] <= '0;
      end
      side_q[0] <= side_in;
    end
  end

  for (genvar i = 1; i <= STEPS; i++) begin : g_stage
    localparam logic [ANG_W-1:0] ATAN = atan_turn(i - 1);
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;

    assign xs = x_q[i-1] >>> (i - 1);
    assign ys = y_q[i-1] >>> (i - 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
      if (en) begin
        if (y_q[i-1] > 0) begin
          x_q[i]   <= x_q[i-1] + ys;
          y_q[i]   <= y_q[i-1] - xs;
          ang_q[i] <= ang_q[i-1] + ATAN;
        end else begin
          x_q[i]   <= x_q[i-1] - ys;
          y_q[i]   <= y_q[i-1] + xs;
          ang_q[i] <= ang_q[i-1] - ATAN;
        end
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign angle     = ang_q[STEPS];
  assign side_out  = side_q[STEPS];

endmodule
